[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_CLK_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/fesd_pkg.sv]
// Types and constants of the flag/escape symbol deframer
`timescale 1ns / 1ps
package fesd_pkg;

  localparam int SymW   = 4;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [0:0] CFG_FLAG = 1'b0;
  localparam logic [0:0] CFG_ESC  = 1'b1;

  localparam logic [SymW-1:0] FLAG_RST = 4'd15;
  localparam logic [SymW-1:0] ESC_RST  = 4'd0;

  localparam logic [SymW-1:0] HDR_A = 4'd4;
  localparam logic [SymW-1:0] HDR_B = 4'd7;
  localparam logic [SymW-1:0] HDR_C = 4'd8;
  localparam logic [SymW-1:0] HDR_D = 4'd11;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            first;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

[hw/rtl/fesd_decode.sv]
// Symbol history, frame state and result generation for one accepted item per cycle
`timescale 1ns / 1ps
module fesd_decode import fesd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_addr,
  input  logic [SymW-1:0] cfg_wdata,
  input  logic            accept,
  input  logic [SymW-1:0] sym,
  output push_t           push
);

  logic [SymW-1:0] flag_r, esc_r, prev_r, prev2_r;
  logic            in_frame_r, pending_r, at_start_r;
  logic            in_frame_nxt, pending_nxt, at_start_nxt;
  logic            stop, hdr;

  assign stop = (sym == flag_r) && ((prev_r != esc_r) || (prev2_r == esc_r));
  assign hdr  = (sym == HDR_A) || (sym == HDR_B) || (sym == HDR_C) || (sym == HDR_D);

  always_comb begin
    in_frame_nxt = in_frame_r;
    pending_nxt  = pending_r;
    at_start_nxt = at_start_r;
    push.cnt     = 2'd0;
    push.r0      = '{sym: sym, first: 1'b0, last: stop};
    push.r1      = '{sym: sym, first: 1'b0, last: stop};
    if (in_frame_r) begin
      push.cnt     = 2'd1;
      in_frame_nxt = !stop;
      at_start_nxt = stop;
    end else if (pending_r && hdr) begin
      push.cnt     = 2'd2;
      push.r0      = '{sym: prev_r, first: 1'b1, last: 1'b0};
      pending_nxt  = 1'b0;
      in_frame_nxt = !stop;
      at_start_nxt = stop;
    end else begin
      pending_nxt  = (sym == flag_r) && (at_start_r || (prev_r != esc_r));
      at_start_nxt = 1'b0;
    end
    if (!accept) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r     <= FLAG_RST;
      esc_r      <= ESC_RST;
      in_frame_r <= 1'b0;
      pending_r  <= 1'b0;
      at_start_r <= 1'b1;
      prev_r     <= '0;
      prev2_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_FLAG: flag_r <= cfg_wdata;
          CFG_ESC:  esc_r  <= cfg_wdata;
          default:  ;
        endcase
      end
      if (accept) begin
        in_frame_r <= in_frame_nxt;
        pending_r  <= pending_nxt;
        at_start_r <= at_start_nxt;
        prev_r     <= sym;
        prev2_r    <= prev_r;
      end
    end
  end

endmodule

[hw/rtl/fesd_outq.sv]
// Result queue: takes up to two results per cycle, delivers one when out_ready is high
`timescale 1ns / 1ps
module fesd_outq import fesd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  result_t           q_r [QDepth];
  logic [QPtrW-1:0]  head_r, tail_r, tail_p1;
  logic [QCntW-1:0]  count_r;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign out_item  = q_r[head_r];
  assign pop       = out_valid && out_ready;
  assign room      = (count_r <= QCntW'(QDepth - 2));
  assign tail_p1   = tail_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[tail_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      q_r[tail_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (pop) begin
        head_r <= head_r + 1'b1;
      end
      tail_r  <= tail_r + QPtrW'(push.cnt);
      count_r <= count_r + QCntW'(push.cnt) - QCntW'(pop);
    end
  end

endmodule

[hw/rtl/flag_escape_symbol_deframer_top.sv]
// Top level of the flag/escape symbol deframer
//
//   channel | direction | tdata              | tuser       | tlast
//   in_     | slave     | [3:0] line_symbol  | -           | -
//   out_    | master     | [3:0] frame_symbol | frame_first | frame_last
//   cfg_    | write     | 0 flag_symbol, 1 escape_symbol, 4-bit data
//
// One input item per cycle while in_tready is high; its results enter the queue on acceptance.
// A confirmed start gives two results, drained one per cycle while out_tready is high
// from a 4-entry queue; in_tready drops while fewer than two queue slots are free.
// Reset is synchronous, active low, clears frame state and the queue, and restores the flag and escape symbols.
`timescale 1ns / 1ps
module flag_escape_symbol_deframer_top import fesd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] line_symbol, [7:4] zero
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] frame_symbol, [7:4] zero
  output logic [0:0] out_tuser,  // [0] frame_first
  output logic       out_tlast,
  input  logic       cfg_we,
  input  logic [0:0] cfg_addr,
  input  logic [3:0] cfg_wdata
);

  push_t   push;
  result_t item;
  logic    accept;

  assign accept = in_tvalid && in_tready;

  fesd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .sym       (in_tdata[SymW-1:0]),
    .push      (push)
  );

  fesd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (item)
  );

  assign out_tdata = {4'b0000, item.sym};
  assign out_tuser = item.first;
  assign out_tlast = item.last;

endmodule

[hw/rtl/fesd_checker.sv]
// Port-level checks of the deframer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fesd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser,
  input logic       out_tlast
);

  `ASSERT_CLK_NR(a_rst_empty, !rst_n |=> !out_tvalid, "output valid right after reset")
  `ASSERT_CLK(a_first_not_last, out_tvalid && out_tuser[0] |-> !out_tlast, "start flag marked last")
  `ASSERT_CLK(a_pad_zero, out_tvalid |-> out_tdata[7:4] == 4'd0, "output pad bits not zero")
  `ASSERT_CLK(a_stall_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled item changed")

endmodule

bind flag_escape_symbol_deframer_top fesd_checker u_fesd_checker (.*);

[verif/flag_escape_symbol_deframer_top_tb.sv]
// Self-checking testbench for the flag/escape symbol deframer top level
`timescale 1ns / 1ps
module flag_escape_symbol_deframer_top_tb;
  import fesd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 12;

  class frame_checker;
    logic [SymW-1:0] flag_sym;
    logic [SymW-1:0] esc_sym;
    bit in_frame;
    bit start_pending;
    bit at_stream_start;
    logic [SymW-1:0] last_sym;
    logic [SymW-1:0] older_sym;
    result_t frame_items_due[$];
    int errors;

    function new();
      flag_sym = FLAG_RST;
      esc_sym = ESC_RST;
      in_frame = 1'b0;
      start_pending = 1'b0;
      at_stream_start = 1'b1;
      last_sym = '0;
      older_sym = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [3:0] value);
      case (idx)
        CFG_FLAG: flag_sym = value;
        CFG_ESC: esc_sym = value;
        default: ;
      endcase
    endfunction

    function bit is_header(logic [SymW-1:0] s);
      return s == HDR_A || s == HDR_B || s == HDR_C || s == HDR_D;
    endfunction

    function bit ends_frame(logic [SymW-1:0] s);
      return s == flag_sym && (last_sym != esc_sym || older_sym == esc_sym);
    endfunction

    function void push_item(logic [SymW-1:0] s, bit first, bit last);
      result_t r;
      r.sym = s;
      r.first = first;
      r.last = last;
      frame_items_due.insert(frame_items_due.size(), r);
    endfunction

    function void note_line_symbol(logic [SymW-1:0] s);
      bit stop;
      if (in_frame) begin
        stop = ends_frame(s);
        push_item(s, 1'b0, stop);
        in_frame = !stop;
        at_stream_start = stop;
      end else if (start_pending && is_header(s)) begin
        stop = ends_frame(s);
        push_item(last_sym, 1'b1, 1'b0);
        push_item(s, 1'b0, stop);
        start_pending = 1'b0;
        in_frame = !stop;
        at_stream_start = stop;
      end else begin
        start_pending = (s == flag_sym) && (at_stream_start || last_sym != esc_sym);
        at_stream_start = 1'b0;
      end
      older_sym = last_sym;
      last_sym = s;
    endfunction

    function void check_frame_item(result_t got);
      result_t want;
      if (frame_items_due.size() == 0) begin
        $error("unexpected item: frame_symbol %0d frame_first %0d frame_last %0d",
               got.sym, got.first, got.last);
        errors++;
        return;
      end
      want = frame_items_due.pop_front();
      if (got.sym !== want.sym) begin
        $error("frame_symbol: expected %0d, actual %0d", want.sym, got.sym);
        errors++;
      end
      if (got.first !== want.first) begin
        $error("frame_first: expected %0d, actual %0d", want.first, got.first);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("frame_last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return frame_items_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [0:0] out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_addr = '0;
  logic [3:0] cfg_wdata = '0;

  frame_checker checker_h = new();
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int rx_hold_cycles = 0;
  int symbols_sent = 0;
  logic [SymW-1:0] cur_flag = FLAG_RST;
  logic [SymW-1:0] cur_esc = ESC_RST;

  flag_escape_symbol_deframer_top u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.sym = out_tdata[SymW-1:0];
        got.first = out_tuser[0];
        got.last = out_tlast;
        checker_h.check_frame_item(got);
      end
      if (in_tvalid && in_tready) checker_h.note_line_symbol(in_tdata[SymW-1:0]);
      if (cfg_we) checker_h.write_reg(cfg_addr, cfg_wdata);
    end
  end

  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      out_tready <= 1'b0;
    end else if (out_idle_on && $urandom_range(99) < 36) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic send_symbol(input logic [SymW-1:0] s);
    while (in_idle_on && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    symbols_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_regs(input logic [SymW-1:0] flag_v, input logic [SymW-1:0] esc_v);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_FLAG;
    cfg_wdata <= flag_v;
    @(negedge clk);
    cfg_addr <= CFG_ESC;
    cfg_wdata <= esc_v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_flag = flag_v;
    cur_esc = esc_v;
  endtask

  task automatic send_list(input logic [SymW-1:0] syms[$]);
    foreach (syms[i]) send_symbol(syms[i]);
  endtask

  function automatic logic [SymW-1:0] pick_header();
    case ($urandom_range(3))
      0: return HDR_A;
      1: return HDR_B;
      2: return HDR_C;
      default: return HDR_D;
    endcase
  endfunction

  task automatic send_frame(input bit broken);
    logic [SymW-1:0] s;
    int body_len;
    repeat ($urandom_range(0, 2)) send_symbol(SymW'($urandom_range(15)));
    send_symbol(cur_flag);
    if (broken && $urandom_range(2) == 0) send_symbol(SymW'($urandom_range(15)));
    else send_symbol(pick_header());
    body_len = $urandom_range(0, 10);
    repeat (body_len) begin
      s = SymW'($urandom_range(15));
      // stuff an escape ahead of any data symbol that matches the flag, unless flag and escape are equal
      if (s == cur_flag && cur_flag != cur_esc) send_symbol(cur_esc);
      send_symbol(s);
    end
    if (!broken || $urandom_range(1) == 0) send_symbol(cur_flag);
  endtask

  task automatic run_phase(input logic [SymW-1:0] flag_v, input logic [SymW-1:0] esc_v,
                           input int n_syms, input bit idle_v, input bit hold_rx);
    int stop_at;
    write_regs(flag_v, esc_v);
    in_idle_on = idle_v;
    out_idle_on = idle_v;
    if (hold_rx) begin
      @(posedge clk);
      rx_hold_cycles = 400;
      @(negedge clk);
    end
    stop_at = symbols_sent + n_syms;
    while (symbols_sent < stop_at) begin
      if ($urandom_range(99) < 20) send_symbol(SymW'($urandom_range(15)));
      else send_frame($urandom_range(99) < 15);
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // frame closed by a double escape ahead of the flag
    send_list('{4'd15, 4'd4, 4'd0, 4'd15, 4'd3, 4'd0, 4'd0, 4'd15});
    // rejected candidate, then a flag retried as candidate
    send_list('{4'd15, 4'd3, 4'd15, 4'd15, 4'd7, 4'd15});
    // escaped flag while hunting, then a plain frame
    send_list('{4'd0, 4'd15, 4'd8, 4'd15, 4'd11, 4'd1, 4'd2, 4'd15});
    wait_drained();
    // header equal to flag closes the frame at once
    write_regs(4'd4, 4'd0);
    send_list('{4'd4, 4'd4});
    wait_drained();
    // flag equal to escape
    write_regs(4'd7, 4'd7);
    send_list('{4'd7, 4'd11, 4'd7, 4'd7, 4'd7});
    wait_drained();

    run_phase(4'd15, 4'd0, 250, 1'b1, 1'b0);
    run_phase(4'd0, 4'd15, 250, 1'b0, 1'b0);
    run_phase(4'd4, 4'd0, 200, 1'b1, 1'b1);
    run_phase(4'd7, 4'd7, 200, 1'b1, 1'b0);
    run_phase(4'd11, 4'd11, 150, 1'b1, 1'b0);
    repeat (4) run_phase(SymW'($urandom_range(15)), SymW'($urandom_range(15)), 240,
                         1'b1, 1'b0);

    repeat (SettleCycles) @(posedge clk);
    if (checker_h.errors == 0 && checker_h.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
